>>> sv/assert_macros.svh
// assertion macros used by the port level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, disabled in reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> sv/stcs_pkg.sv
// types and constants for the sparse tensor coordinate sorter
// no dependencies
package stcs_pkg;

    localparam int unsigned PORT_MODES = 4;
    localparam int unsigned PORT_COORD_BITS = 32;
    localparam int unsigned VALUE_BITS = 64;
    localparam int unsigned MODES_BITS = 3;
    localparam logic [MODES_BITS-1:0] MODES_RESET = 3'd3;

    typedef struct packed {
        logic [PORT_MODES-1:0][PORT_COORD_BITS-1:0] coord;
        logic [VALUE_BITS-1:0]                      value;
        logic                                       last;
    } entry_t;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } back_state_t;

endpackage

>>> sv/stcs_if.sv
// item channels of the sorter: input entries and sorted results
// no dependencies
interface stcs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] coord_a;
    logic [31:0] coord_b;
    logic [31:0] coord_c;
    logic [31:0] coord_d;
    logic [63:0] value_bits;
    logic        is_last;

    modport source (output valid, coord_a, coord_b, coord_c, coord_d, value_bits, is_last,
                    input ready);
    modport sink (input valid, coord_a, coord_b, coord_c, coord_d, value_bits, is_last,
                  output ready);
endinterface

interface stcs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_coord_a;
    logic [31:0] out_coord_b;
    logic [31:0] out_coord_c;
    logic [31:0] out_coord_d;
    logic [63:0] out_value_bits;
    logic        out_last;
    logic        overflow;

    modport source (output valid, out_coord_a, out_coord_b, out_coord_c, out_coord_d,
                    out_value_bits, out_last, overflow, input ready);
    modport sink (input valid, out_coord_a, out_coord_b, out_coord_c, out_coord_d,
                  out_value_bits, out_last, overflow, output ready);
endinterface

>>> sv/stcs_front.sv
// front end: accepts entries and queues them for the sorting cells
// depends on stcs_pkg and stcs_in_if
module stcs_front
    import stcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    stcs_in_if.sink in_ch,
    output entry_t  q_data,
    output logic    q_valid,
    input  logic    q_pop
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    entry_t     in_entry;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign pop = q_pop && (cnt_reg != 2'd0);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        in_entry.coord[0] = in_ch.coord_a;
        in_entry.coord[1] = in_ch.coord_b;
        in_entry.coord[2] = in_ch.coord_c;
        in_entry.coord[3] = in_ch.coord_d;
        in_entry.value = in_ch.value_bits;
        in_entry.last = in_ch.is_last;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> sv/stcs_back.sv
// back end: insertion cell chain that keeps entries sorted, then drains them
// depends on stcs_pkg and stcs_out_if
module stcs_back
    import stcs_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned MAX_MODES = 4,
    parameter int unsigned COORD_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [MODES_BITS-1:0] num_modes,
    input  entry_t                q_data,
    input  logic                  q_valid,
    output logic                  q_pop,
    stcs_out_if.source            out_ch
);

    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

    logic [COORD_BITS-1:0] coord_reg [MAX_ENTRIES][MAX_MODES];
    logic [VALUE_BITS-1:0] value_reg [MAX_ENTRIES];
    logic [CW-1:0]         count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    back_state_t           state_reg, state_next;

    logic [COORD_BITS-1:0]  new_coord [MAX_MODES];
    logic [MAX_ENTRIES-1:0] gt;
    logic [MODES_BITS-1:0]  modes;
    logic                   full, insert, shift_out;

    always_comb
    begin
        if (num_modes == '0)
            modes = MODES_BITS'(1);
        else if (32'(num_modes) > MAX_MODES)
            modes = MODES_BITS'(MAX_MODES);
        else
            modes = num_modes;
    end

    assign full = (count_reg == CW'(MAX_ENTRIES));
    assign q_pop = (state_reg == ST_FILL) && q_valid;
    assign insert = q_pop && !full;
    assign shift_out = (state_reg == ST_DRAIN) && out_ch.ready;

    genvar gi, gk;
    generate
        for (gk = 0; gk < MAX_MODES; gk++)
        begin : g_in
            logic [63:0] wide_in;
            assign wide_in = 64'(q_data.coord[gk]);
            assign new_coord[gk] = wide_in[COORD_BITS-1:0];
        end

        // empty cells count as greater, so the chain stays ordered
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cmp
            always_comb
            begin
                logic decided;
                logic greater;
                decided = 1'b0;
                greater = 1'b0;
                for (int k = 0; k < MAX_MODES; k++)
                begin
                    if (MODES_BITS'(k) < modes && !decided)
                    begin
                        if (coord_reg[gi][k] > new_coord[k])
                        begin
                            greater = 1'b1;
                            decided = 1'b1;
                        end
                        else if (coord_reg[gi][k] < new_coord[k])
                        begin
                            decided = 1'b1;
                        end
                    end
                end
                gt[gi] = (CW'(gi) >= count_reg) || greater;
            end
        end

        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            always_ff @(posedge clk)
            begin
                if (insert && gt[gi])
                begin
                    if (gi == 0 || !gt[(gi == 0) ? 0 : gi - 1])
                    begin
                        coord_reg[gi] <= new_coord;
                        value_reg[gi] <= q_data.value;
                    end
                    else
                    begin
                        coord_reg[gi] <= coord_reg[(gi == 0) ? 0 : gi - 1];
                        value_reg[gi] <= value_reg[(gi == 0) ? 0 : gi - 1];
                    end
                end
                else if (shift_out && gi + 1 < MAX_ENTRIES)
                begin
                    coord_reg[gi] <= coord_reg[(gi + 1 < MAX_ENTRIES) ? gi + 1 : gi];
                    value_reg[gi] <= value_reg[(gi + 1 < MAX_ENTRIES) ? gi + 1 : gi];
                end
            end
        end
    endgenerate

    logic [PORT_MODES-1:0][PORT_COORD_BITS-1:0] out_coord;
    generate
        for (gk = 0; gk < PORT_MODES; gk++)
        begin : g_out
            if (gk < MAX_MODES)
            begin : g_used
                logic [63:0] wide_out;
                assign wide_out = 64'(coord_reg[0][gk]);
                assign out_coord[gk] = wide_out[PORT_COORD_BITS-1:0];
            end
            else
            begin : g_unused
                assign out_coord[gk] = '0;
            end
        end
    endgenerate

    assign out_ch.valid = (state_reg == ST_DRAIN);
    assign out_ch.out_coord_a = out_coord[0];
    assign out_ch.out_coord_b = out_coord[1];
    assign out_ch.out_coord_c = out_coord[2];
    assign out_ch.out_coord_d = out_coord[3];
    assign out_ch.out_value_bits = value_reg[0];
    assign out_ch.out_last = (count_reg == CW'(1));
    assign out_ch.overflow = ovf_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (q_pop)
                begin
                    if (full)
                        ovf_next = 1'b1;
                    else
                        count_next = count_reg + CW'(1);
                    if (q_data.last)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (shift_out)
                begin
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        state_next = ST_FILL;
                        ovf_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            count_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

>>> sv/sparse_tensor_coordinate_sort.sv
// sparse tensor coordinate sorter: lexicographic stable sort of one set of entries
// an entry taken at the input waits in the front queue and enters the cell chain when popped, unless the chain is full
// throughput: one entry per cycle while filling; a set drains while the receiver is ready
// the first result shows once the last entry has left the front queue and the state register has switched to draining
// reset: asynchronous active low, empties queue and chain, num_modes returns to 3
// depends on stcs_pkg, stcs_if, stcs_front, stcs_back
module sparse_tensor_coordinate_sort
    import stcs_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned MAX_MODES = 4,
    parameter int unsigned COORD_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    stcs_in_if.sink               in_ch,
    stcs_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [MODES_BITS-1:0] cfg_wdata
);

    logic [MODES_BITS-1:0] num_modes_reg;
    entry_t                q_data;
    logic                  q_valid, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_modes_reg <= MODES_RESET;
        else if (cfg_we)
            num_modes_reg <= cfg_wdata;
    end

    stcs_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    stcs_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_MODES   (MAX_MODES),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_modes (num_modes_reg),
        .q_data    (q_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .out_ch    (out_ch)
    );

endmodule

>>> sv/stcs_checker.sv
// port level checks for the sorter, bound to the top level
// depends on assert_macros.svh and sparse_tensor_coordinate_sort
`include "assert_macros.svh"

module stcs_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_last,
    input logic        overflow,
    input logic [63:0] out_value_bits
);

    // stalled result holds
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_value_bits))
    // overflow is one flag per set
    `ASSERT_CLK(a_ovf_set, clk, rst_n, out_valid && out_ready && !out_last |=> out_valid && $stable(overflow))
    // a set ends with a gap before the next one
    `ASSERT_CLK(a_gap_after_last, clk, rst_n, out_valid && out_ready && out_last |=> !out_valid)
    // nothing leaves right after a reset cycle
    `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid)

endmodule

bind sparse_tensor_coordinate_sort stcs_port_checker u_stcs_port_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_last       (out_ch.out_last),
    .overflow       (out_ch.overflow),
    .out_value_bits (out_ch.out_value_bits)
);

>>> test/stcs_test_pkg.sv
// shared constants for the sorter testbench: capacity and register range
// depends on stcs_pkg
package stcs_test_pkg;
    import stcs_pkg::*;

    localparam int unsigned SET_CAPACITY = 64;
    localparam int unsigned MODES_MIN = 1;
    localparam int unsigned MODES_MAX = 4;

endpackage

>>> test/stcs_test_if.sv
// interfaces used by the sorter testbench are those of the block (stcs_if)
// this file holds the configuration port bundle seen by the checker
// depends on stcs_pkg
interface stcs_cfg_if;
    import stcs_pkg::*;
    logic                  we;
    logic [MODES_BITS-1:0] wdata;

    modport source (output we, wdata);
    modport sink (input we, wdata);
endinterface

>>> test/stcs_checker.sv
// checker for the sorter: watches entry and result channels and the register port,
// sorts each set stably by the configured modes and compares every result
// depends on stcs_pkg, stcs_test_pkg, stcs_if, stcs_test_if
module stcs_checker
    import stcs_pkg::*;
    import stcs_test_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    stcs_in_if.sink    in_mon,
    stcs_out_if.sink   out_mon,
    stcs_cfg_if.sink   cfg_mon,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [63:0] value;
        logic        last;
        logic        ovf;
    } sorted_entry_t;

    sorted_entry_t held_set[$];
    sorted_entry_t sorted_queue[$];
    logic          dropped;
    int unsigned   sort_modes;

    function automatic logic [31:0] mode_coord(sorted_entry_t e, int unsigned k);
        case (k)
            0: mode_coord = e.a;
            1: mode_coord = e.b;
            2: mode_coord = e.c;
            default: mode_coord = e.d;
        endcase
    endfunction

    function automatic bit sorts_after(sorted_entry_t x, sorted_entry_t y, int unsigned m);
        for (int unsigned k = 0; k < m; k++)
        begin
            if (mode_coord(x, k) > mode_coord(y, k))
                return 1'b1;
            if (mode_coord(x, k) < mode_coord(y, k))
                return 1'b0;
        end
        return 1'b0;
    endfunction

    task automatic release_sorted_set();
        sorted_entry_t t;
        int j;
        for (int i = 1; i < held_set.size(); i++)
        begin
            j = i;
            while (j > 0 && sorts_after(held_set[j-1], held_set[j], sort_modes))
            begin
                t = held_set[j];
                held_set[j] = held_set[j-1];
                held_set[j-1] = t;
                j--;
            end
        end
        for (int i = 0; i < held_set.size(); i++)
        begin
            t = held_set[i];
            t.last = (i == held_set.size() - 1);
            t.ovf = dropped;
            sorted_queue.push_back(t);
        end
        held_set.delete();
        dropped = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sorted_entry_t e;
        sorted_entry_t got;
        if (!rst_n)
        begin
            held_set.delete();
            sorted_queue.delete();
            dropped = 1'b0;
            sort_modes = MODES_RESET;
            fail_count = 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                got = '{out_mon.out_coord_a, out_mon.out_coord_b, out_mon.out_coord_c,
                        out_mon.out_coord_d, out_mon.out_value_bits, out_mon.out_last,
                        out_mon.overflow};
                if (sorted_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    e = sorted_queue.pop_front();
                    if (got !== e)
                    begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, e, got);
                        fail_count++;
                    end
                end
            end
            if (cfg_mon.we)
            begin
                sort_modes = cfg_mon.wdata;
                if (sort_modes < MODES_MIN)
                    sort_modes = MODES_MIN;
                if (sort_modes > MODES_MAX)
                    sort_modes = MODES_MAX;
            end
            if (in_mon.valid && in_mon.ready)
            begin
                if (held_set.size() < SET_CAPACITY)
                    held_set.push_back('{in_mon.coord_a, in_mon.coord_b, in_mon.coord_c,
                                         in_mon.coord_d, in_mon.value_bits, 1'b0, 1'b0});
                else
                    dropped = 1'b1;
                if (in_mon.is_last)
                    release_sorted_set();
            end
        end
        pending = sorted_queue.size();
    end

endmodule

>>> test/sparse_tensor_coordinate_sort_test.sv
// top of the sorter testbench: clock, reset, register writes and entry stimulus
// with random idling and stalls; the checker predicts and counts failures
// depends on stcs_pkg, stcs_test_pkg, stcs_if, stcs_test_if, stcs_checker
module sparse_tensor_coordinate_sort_test;
    import stcs_pkg::*;
    import stcs_test_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_cycles = 0;
    int   entries_sent = 0;

    stcs_in_if  in_ch();
    stcs_out_if out_ch();
    stcs_cfg_if cfg();

    sparse_tensor_coordinate_sort DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .cfg_we(cfg.we),
        .cfg_wdata(cfg.wdata)
    );

    stcs_checker checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .in_mon(in_ch.sink),
        .out_mon(out_ch.sink),
        .cfg_mon(cfg.sink),
        .fail_count(fail_count),
        .pending(pending)
    );

    always #10 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.coord_a = '0;
        in_ch.coord_b = '0;
        in_ch.coord_c = '0;
        in_ch.coord_d = '0;
        in_ch.value_bits = '0;
        in_ch.is_last = 1'b0;
        out_ch.ready = 1'b0;
        cfg.we = 1'b0;
        cfg.wdata = '0;
    end

    // receiver: random stalls, or a long counted hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [31:0] pick_coord(int unsigned spread);
        case ($urandom_range(5))
            0: pick_coord = 32'd0;
            1: pick_coord = 32'hFFFF_FFFF;
            2: pick_coord = $urandom;
            default: pick_coord = $urandom_range(spread);
        endcase
    endfunction

    task automatic send_entry(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                              logic [31:0] d, logic [63:0] v, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.coord_a <= a;
        in_ch.coord_b <= b;
        in_ch.coord_c <= c;
        in_ch.coord_d <= d;
        in_ch.value_bits <= v;
        in_ch.is_last <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        entries_sent++;
    endtask

    task automatic send_set(int unsigned n, int unsigned spread);
        for (int unsigned i = 0; i < n; i++)
            send_entry(pick_coord(spread), pick_coord(spread), pick_coord(spread),
                       pick_coord(spread), {$urandom, $urandom}, i == n - 1);
    endtask

    task automatic settle_and_write(logic [MODES_BITS-1:0] modes);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg.we <= 1'b1;
        cfg.wdata <= modes;
        @(posedge clk);
        cfg.we <= 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default modes, extremes, ties, single entry
        send_entry('1, '1, '1, '1, '1, 1'b0);
        send_entry('0, '0, '0, '0, '0, 1'b0);
        send_entry(32'd5, 32'd1, 32'd9, 32'd0, 64'h1, 1'b0);
        send_entry(32'd5, 32'd1, 32'd9, 32'd7, 64'h2, 1'b0);
        send_entry(32'd5, 32'd1, 32'd2, 32'd3, 64'h3, 1'b1);
        send_entry(32'h8000_0000, 32'd1, 32'd1, 32'd1, 64'h8000_0000_0000_0000, 1'b1);
        settle_and_write(3'd0);
        send_entry(32'd2, 32'd9, 32'd0, 32'd0, 64'hA, 1'b0);
        send_entry(32'd2, 32'd1, 32'd0, 32'd0, 64'hB, 1'b0);
        send_entry(32'd1, 32'd5, 32'd0, 32'd0, 64'hC, 1'b1);
        settle_and_write(3'd7);
        send_entry(32'd1, 32'd1, 32'd1, 32'd9, 64'hD, 1'b0);
        send_entry(32'd1, 32'd1, 32'd1, 32'd2, 64'hE, 1'b1);
        // overflow: one full set plus dropped entries, the last one dropped too
        settle_and_write(3'd1);
        send_set(SET_CAPACITY + 3, 4);

        // random phases with differing register settings and idling
        for (int phase = 0; phase < 8; phase++)
        begin
            settle_and_write(phase % 2 ? 3'd4 : 3'($urandom_range(7)));
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if (phase == 2)
                hold_cycles = 300;
            for (int s = 0; s < 4; s++)
                send_set($urandom_range(1, 12), $urandom_range(1) ? 3 : 32'hFFFF_FFFF);
        end
        send_idle_pct = 20;
        recv_stall_pct = 20;
        while (entries_sent < 430)
            send_set($urandom_range(1, 16), 5);

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/stcs_pkg.sv
sv/stcs_if.sv
sv/stcs_front.sv
sv/stcs_back.sv
sv/sparse_tensor_coordinate_sort.sv
sv/stcs_checker.sv
test/stcs_test_pkg.sv
test/stcs_test_if.sv
test/stcs_checker.sv
test/sparse_tensor_coordinate_sort_test.sv
